// ----- src/cse_pkg.sv -----
package cse_pkg;

  // Default sizes of the storage.
  localparam int unsigned MAX_FUNCS_DEF   = 256;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FID_W   = 8;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NFUNC_W = 9;

  localparam logic [NFUNC_W-1:0] NFUNC_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_ID    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_POP,
    S_CHILD,
    S_ACCUM
  } state_t;

endpackage

// ----- src/cse_stack_mem.sv -----
module cse_stack_mem
  import cse_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned TW    = TIME_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  // Read of the top entry and of the child time of the entry beneath it.
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [FID_W-1:0] rd_func,
  output logic [TW-1:0]    rd_start,
  output logic [TW-1:0]    rd_child,
  output logic [TW-1:0]    rd_child_b,
  // Push writes a whole entry with a cleared child time.
  input  logic             push_en,
  input  logic [AW-1:0]    push_addr,
  input  logic [FID_W-1:0] push_func,
  input  logic [TW-1:0]    push_start,
  // Child time update of the entry that becomes the top after a pop.
  input  logic             child_en,
  input  logic [AW-1:0]    child_addr,
  input  logic [TW-1:0]    child_data
);

  logic [FID_W-1:0] func_mem  [DEPTH];
  logic [TW-1:0]    start_mem [DEPTH];
  logic [TW-1:0]    child_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (push_en) begin
      func_mem[push_addr]  <= push_func;
      start_mem[push_addr] <= push_start;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      child_mem[push_addr] <= '0;
    end else if (child_en) begin
      child_mem[child_addr] <= child_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_func    <= func_mem[rd_addr_a];
    rd_start   <= start_mem[rd_addr_a];
    rd_child   <= child_mem[rd_addr_a];
    rd_child_b <= child_mem[rd_addr_b];
  end

endmodule

// ----- src/cse_totals_mem.sv -----
module cse_totals_mem
  import cse_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_FUNCS_DEF,
  parameter int unsigned TW    = TIME_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [TW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [TW-1:0] wr_data,
  output logic          busy
);

  logic [TW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_cnt;

  // After reset every entry is zeroed, one per cycle, before any request.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/call_stack_exclusive_time_top.sv -----
// Call-stack exclusive-time profiler. Each accepted request is a parsed trace
// event: a function start (cmd 0), a function end (cmd 1) or a read of one
// function's running total (cmd 2), and each request gives exactly one result.
// A start pushes the function id and start time on a hardware stack; an end
// pops it, reports the call's exclusive time (inclusive span minus the time
// spent in callees), adds it to the function's saturating total and charges
// the span to the caller's child time. Start, read and ignored commands go
// through one memory read, then the result; an end goes through the stack
// read, span, child-time write-back and totals read-modify-write. The result
// sits in an output register, so a request is taken while the previous result
// waits; a stalled result holds the engine in its last step. After reset the
// totals memory is zeroed in a sweep over all MAX_FUNCS entries, during which
// no request is taken; the num_functions register can be written at any time
// the engine is idle.
module call_stack_exclusive_time_top
  import cse_pkg::*;
#(
  parameter int unsigned MAX_FUNCS   = MAX_FUNCS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [FID_W-1:0]   func_id,
  input  logic [TS_W-1:0]    timestamp,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FID_W-1:0]   result_func,
  output logic [OUT_W-1:0]   call_exclusive,
  output logic [OUT_W-1:0]   total_time,
  output logic [STAT_W-1:0]  status,
  // Configuration channel: num_functions.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [NFUNC_W-1:0] cfg_data
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FAW  = $clog2(MAX_FUNCS);

  // Saturating add at the time width.
  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  state_t             state, state_next;
  logic [NFUNC_W-1:0] num_functions;
  logic [SPW-1:0]     sp;

  // Request held while it is worked on; on an end the id becomes the popped id.
  logic [CMD_W-1:0]   cmd_q;
  logic [FID_W-1:0]   id_q;
  logic [TW-1:0]      ts_q;
  logic [TW-1:0]      span_q;
  logic [TW-1:0]      child_q;
  logic [TW-1:0]      parent_q;
  logic [TW-1:0]      ex_q;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic               push_en;
  logic               child_en;
  logic               tot_we;
  logic               id_ok;
  logic               stack_full;
  logic               clr_busy;

  logic [FID_W-1:0]   res_func;
  logic [TW-1:0]      res_ex;
  logic [TW-1:0]      res_total;
  status_t            res_status;

  logic [SAW-1:0]     st_rd_addr_a;
  logic [SAW-1:0]     st_rd_addr_b;
  logic [FID_W-1:0]   st_rd_func;
  logic [TW-1:0]      st_rd_start;
  logic [TW-1:0]      st_rd_child;
  logic [TW-1:0]      st_rd_child_b;
  logic [TW-1:0]      child_wdata;

  logic [FAW-1:0]     tot_rd_addr;
  logic [TW-1:0]      tot_rd_data;
  logic [TW-1:0]      tot_new;

  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign id_ok      = ({1'b0, id_q} < num_functions) && (32'(id_q) < 32'(MAX_FUNCS));
  assign stack_full = (sp == SPW'(STACK_DEPTH));
  assign tot_new    = sat_add(tot_rd_data, ex_q);
  assign child_wdata = sat_add(parent_q, span_q);

  // Stack reads always look at the top entry and the one beneath it.
  assign st_rd_addr_a = SAW'(sp - SPW'(1));
  assign st_rd_addr_b = SAW'(sp - SPW'(2));

  // Totals are read at the requested id, then at the popped id on an end.
  always_comb begin
    case (state)
      S_IDLE:  tot_rd_addr = FAW'(func_id);
      S_POP:   tot_rd_addr = FAW'(st_rd_func);
      default: tot_rd_addr = FAW'(id_q);
    endcase
  end

  cse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .TW    (TW)
  ) u_stack (
    .clk        (clk),
    .rd_addr_a  (st_rd_addr_a),
    .rd_addr_b  (st_rd_addr_b),
    .rd_func    (st_rd_func),
    .rd_start   (st_rd_start),
    .rd_child   (st_rd_child),
    .rd_child_b (st_rd_child_b),
    .push_en    (push_en),
    .push_addr  (SAW'(sp)),
    .push_func  (id_q),
    .push_start (ts_q),
    .child_en   (child_en),
    .child_addr (SAW'(sp - SPW'(1))),
    .child_data (child_wdata)
  );

  cse_totals_mem #(
    .DEPTH (MAX_FUNCS),
    .TW    (TW)
  ) u_totals (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (tot_rd_addr),
    .rd_data (tot_rd_data),
    .wr_en   (tot_we),
    .wr_addr (FAW'(id_q)),
    .wr_data (tot_new),
    .busy    (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit       = 1'b0;
    push_en    = 1'b0;
    child_en   = 1'b0;
    tot_we     = 1'b0;
    res_func   = id_q;
    res_ex     = '0;
    res_total  = '0;
    res_status = ST_OK;
    case (state)
      S_IDLE: begin
        in_ready = !clr_busy;
        if (in_valid && !clr_busy) begin
          if ((cmd == CMD_END) && (sp != '0)) begin
            state_next = S_POP;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        case (cmd_q)
          CMD_START: begin
            if (!id_ok) begin
              res_status = ST_BAD_ID;
            end else if (stack_full) begin
              res_total  = tot_rd_data;
              res_status = ST_OVERFLOW;
            end else begin
              res_total = tot_rd_data;
              push_en   = out_free;
            end
          end
          CMD_END: begin
            // Only an end on an empty stack finishes here.
            res_func   = '0;
            res_status = ST_UNDERFLOW;
          end
          CMD_READ: begin
            if (id_ok) begin
              res_total = tot_rd_data;
            end else begin
              res_status = ST_BAD_ID;
            end
          end
          default: begin
          end
        endcase
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        state_next = S_CHILD;
      end
      S_CHILD: begin
        // The caller, if any, is charged with the whole span of the call.
        child_en   = (sp != '0);
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        res_ex = ex_q;
        if (id_ok) begin
          res_total = tot_new;
        end else begin
          res_status = ST_BAD_ID;
        end
        if (out_free) begin
          emit       = 1'b1;
          tot_we     = id_ok;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_functions <= NFUNC_RESET;
    end else if (cfg_valid) begin
      num_functions <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (push_en) begin
      sp <= sp + SPW'(1);
    end else if (state == S_POP) begin
      sp <= sp - SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      id_q  <= func_id;
      ts_q  <= TW'(timestamp);
    end
    if (state == S_POP) begin
      id_q     <= st_rd_func;
      span_q   <= ts_q - st_rd_start + TW'(1);
      child_q  <= st_rd_child;
      parent_q <= st_rd_child_b;
    end
    if (state == S_CHILD) begin
      ex_q <= (span_q >= child_q) ? (span_q - child_q) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_func    <= res_func;
      call_exclusive <= OUT_W'(res_ex);
      total_time     <= OUT_W'(res_total);
      status         <= res_status;
    end
  end

endmodule
